FILE: hw/rtl/fixed_distance_drive_sequencer_macros.svh
`ifndef FIXED_DISTANCE_DRIVE_SEQUENCER_MACROS_SVH
`define FIXED_DISTANCE_DRIVE_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FDDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FDDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/fdds_pkg.sv
package fdds_pkg;

   localparam int TARGET_BITS    = 31;
   localparam int MAGNITUDE_BITS = 15;
   localparam int DRIVE_BITS     = 16;
   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS  = 32;

   localparam int RSP_BITS = DRIVE_BITS + 3 + TARGET_BITS;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [TARGET_BITS-1:0]    TRAVEL_MAX         = 31'h7FFF_FFFF;
   localparam logic [TARGET_BITS-1:0]    TARGET_RESET       = 31'd2500;
   localparam logic [MAGNITUDE_BITS-1:0] MAGNITUDE_RESET    = 15'd1000;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TARGET_COUNT    = 8'd0,
      CSR_DRIVE_MAGNITUDE = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic fwd_hit;
      logic bwd_hit;
   } wheel_status_type;

endpackage

FILE: hw/rtl/fdds_wheel_check.sv
module fdds_wheel_check #(
   parameter int COUNT_BITS = 32
) (
   input  logic [COUNT_BITS-1:0]            now,
   input  logic [COUNT_BITS-1:0]            start,
   input  logic [fdds_pkg::TARGET_BITS-1:0] target,
   output logic [COUNT_BITS-1:0]            diff,
   output fdds_pkg::wheel_status_type       status
);
   import fdds_pkg::*;

   localparam int CMP_BITS = (COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS + 1;

   logic signed [CMP_BITS-1:0] diff_ext;
   logic signed [CMP_BITS-1:0] tgt_pos;
   logic signed [CMP_BITS-1:0] tgt_neg;

   // wraps modulo 2^COUNT_BITS, read as signed
   assign diff     = now - start;
   assign diff_ext = CMP_BITS'($signed(diff));
   assign tgt_pos  = $signed({{(CMP_BITS-TARGET_BITS){1'b0}}, target});
   assign tgt_neg  = -tgt_pos;

   assign status.fwd_hit = (diff_ext >= tgt_pos);
   assign status.bwd_hit = (diff_ext <= tgt_neg);

endmodule

FILE: hw/rtl/fixed_distance_drive_sequencer.sv
// Channel  Dir  Fields (low bit first)
// req      in   WHEELS x count (COUNT_BITS), stop_key, forward_key, backward_key
// rsp      out  motor_drive[16], going_forward, going_backward, reached, travelled[31]
// csr      in   csr_index (0 target_count, 1 drive_magnitude), csr_data
//
// One item per cycle sustained unless rsp stalls; input register, then result register.
// Per-wheel subtract and compare plus drive/mode update sit between the two registers.
// rsp stalls propagate back through one input stage; req waits only once that stage is full.
// Synchronous reset clears control state and loads register defaults.
// csr_ready is always high; writes are expected only while the block is idle.
`include "fixed_distance_drive_sequencer_macros.svh"

module fixed_distance_drive_sequencer #(
   parameter int COUNT_BITS = 32,
   parameter int WHEELS     = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // counts[WHEELS*COUNT_BITS], stop_key, forward_key, backward_key, zero pad
   input  logic [(((WHEELS*COUNT_BITS)+3+7)/8)*8-1:0] req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // motor_drive[15:0], going_forward, going_backward, reached, travelled[30:0], zero pad
   output logic [fdds_pkg::RSP_W-1:0]           rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [fdds_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fdds_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import fdds_pkg::*;

   localparam int IN_BITS = WHEELS * COUNT_BITS + 3;
   localparam int IN_W    = ((IN_BITS + 7) / 8) * 8;
   localparam int MAG_W   = (COUNT_BITS > TARGET_BITS) ? COUNT_BITS : TARGET_BITS;

   logic                      s1_valid_ff, s1_valid_in;
   logic [IN_W-1:0]           s1_data_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]          rsp_data_ff, rsp_data_in;
   logic                      fwd_prev_ff, bwd_prev_ff;
   logic                      fwd_mode_ff, fwd_mode_in;
   logic                      bwd_mode_ff, bwd_mode_in;
   logic                      finished_ff, finished_in;
   logic [DRIVE_BITS-1:0]     drive_ff, drive_in;
   logic [COUNT_BITS-1:0]     start_ff [WHEELS];
   logic [TARGET_BITS-1:0]    target_ff;
   logic [MAGNITUDE_BITS-1:0] magnitude_ff;

   logic                      advance;
   logic                      stop_key, fwd_key, bwd_key;
   logic                      fwd_edge, bwd_edge, capture;
   logic [COUNT_BITS-1:0]     now      [WHEELS];
   logic [COUNT_BITS-1:0]     start_sel[WHEELS];
   logic [COUNT_BITS-1:0]     diff     [WHEELS];
   wheel_status_type          status   [WHEELS];
   logic [WHEELS-1:0]         fwd_hits, bwd_hits;
   logic                      all_hit, check, reached;
   logic [COUNT_BITS-1:0]     mag;
   logic [MAG_W-1:0]          mag_ext;
   logic [TARGET_BITS-1:0]    travelled;
   logic [DRIVE_BITS-1:0]     drive_pos;

   assign advance     = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready  = ~s1_valid_ff | advance;
   assign s1_valid_in = req_tvalid & req_tready ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   assign csr_ready   = 1'b1;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   assign stop_key = s1_data_ff[WHEELS*COUNT_BITS];
   assign fwd_key  = s1_data_ff[WHEELS*COUNT_BITS+1];
   assign bwd_key  = s1_data_ff[WHEELS*COUNT_BITS+2];
   assign fwd_edge = fwd_key & ~fwd_prev_ff;
   assign bwd_edge = bwd_key & ~bwd_prev_ff;
   assign capture  = fwd_edge | bwd_edge;

   for (genvar w = 0; w < WHEELS; w++) begin : g_wheel
      assign now[w]       = s1_data_ff[w*COUNT_BITS +: COUNT_BITS];
      assign start_sel[w] = capture ? now[w] : start_ff[w];
      assign fwd_hits[w]  = status[w].fwd_hit;
      assign bwd_hits[w]  = status[w].bwd_hit;

      fdds_wheel_check #(
         .COUNT_BITS (COUNT_BITS)
      ) u_check (
         .now    (now[w]),
         .start  (start_sel[w]),
         .target (target_ff),
         .diff   (diff[w]),
         .status (status[w])
      );
   end

   assign drive_pos = {1'b0, magnitude_ff};
   assign mag       = diff[0][COUNT_BITS-1] ? (~diff[0] + 1'b1) : diff[0];
   assign mag_ext   = MAG_W'(mag);
   assign travelled = (mag_ext > MAG_W'(TRAVEL_MAX)) ? TRAVEL_MAX : mag_ext[TARGET_BITS-1:0];

   always_comb begin
      fwd_mode_in = fwd_mode_ff;
      bwd_mode_in = bwd_mode_ff;
      finished_in = finished_ff;
      drive_in    = drive_ff;
      reached     = 1'b0;
      if (stop_key) begin
         fwd_mode_in = 1'b0;
         bwd_mode_in = 1'b0;
         finished_in = 1'b0;
         drive_in    = '0;
      end
      if (fwd_edge) begin
         fwd_mode_in = 1'b1;
         bwd_mode_in = 1'b0;
         finished_in = 1'b0;
         drive_in    = drive_pos;
      end
      if (bwd_edge) begin
         bwd_mode_in = 1'b1;
         fwd_mode_in = 1'b0;
         finished_in = 1'b0;
         drive_in    = -drive_pos;
      end
      check   = (fwd_mode_in | bwd_mode_in) & (drive_in != '0) & ~finished_in;
      all_hit = drive_in[DRIVE_BITS-1] ? (&bwd_hits) : (&fwd_hits);
      if (check && all_hit) begin
         finished_in = 1'b1;
         drive_in    = '0;
         reached     = 1'b1;
      end
      rsp_data_in = RSP_W'({(reached ? travelled : {TARGET_BITS{1'b0}}), reached,
                            bwd_mode_in, fwd_mode_in, drive_in});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_prev_ff  <= 1'b0;
         bwd_prev_ff  <= 1'b0;
         fwd_mode_ff  <= 1'b0;
         bwd_mode_ff  <= 1'b0;
         finished_ff  <= 1'b0;
         drive_ff     <= '0;
         target_ff    <= TARGET_RESET;
         magnitude_ff <= MAGNITUDE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            fwd_prev_ff <= fwd_key;
            bwd_prev_ff <= bwd_key;
            fwd_mode_ff <= fwd_mode_in;
            bwd_mode_ff <= bwd_mode_in;
            finished_ff <= finished_in;
            drive_ff    <= drive_in;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TARGET_COUNT:    target_ff    <= csr_data[TARGET_BITS-1:0];
               CSR_DRIVE_MAGNITUDE: magnitude_ff <= csr_data[MAGNITUDE_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         if (capture) begin
            for (int w = 0; w < WHEELS; w++) begin
               start_ff[w] <= now[w];
            end
         end
      end
   end

   `FDDS_ASSERT_NOW(a_modes_exclusive, clock, reset, 1'b1, !(fwd_mode_ff && bwd_mode_ff), "both modes set")
   `FDDS_ASSERT_NOW(a_drive_has_mode, clock, reset, drive_ff != '0, fwd_mode_ff || bwd_mode_ff, "drive without mode")
   `FDDS_ASSERT_NOW(a_drive_sign, clock, reset, (drive_ff != '0) && !drive_ff[DRIVE_BITS-1], fwd_mode_ff, "positive drive outside forward mode")
   `FDDS_ASSERT_NOW(a_reached_stops, clock, reset, rsp_valid_ff && rsp_data_ff[DRIVE_BITS+2], rsp_data_ff[DRIVE_BITS-1:0] == '0, "reached with drive on")
   `FDDS_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_valid_ff, "result register not loaded")

endmodule

FILE: dv/fixed_distance_drive_sequencer_test.sv
module fixed_distance_drive_sequencer_test;
   import fdds_pkg::*;

   localparam int COUNT_BITS = 32;
   localparam int WHEELS     = 4;
   localparam int REQ_W      = (((WHEELS * COUNT_BITS) + 3 + 7) / 8) * 8;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_UNUSED = 8'hFF;

   typedef struct packed {
      logic                                 backward_key;
      logic                                 forward_key;
      logic                                 stop_key;
      logic [WHEELS-1:0][COUNT_BITS-1:0]    count;
   } tick_type;

   typedef struct packed {
      logic [TARGET_BITS-1:0]  travelled;
      logic                    reached;
      logic                    going_backward;
      logic                    going_forward;
      logic [DRIVE_BITS-1:0]   motor_drive;
   } drive_status_type;

   typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_pattern_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   fixed_distance_drive_sequencer #(
      .COUNT_BITS(COUNT_BITS),
      .WHEELS    (WHEELS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   tick_type         ticks_to_send[$];
   drive_status_type predicted_outputs[$];

   // shadow registers and sequencer state
   logic [TARGET_BITS-1:0]            target_cfg;
   logic [MAGNITUDE_BITS-1:0]         magnitude_cfg;
   logic [WHEELS-1:0][COUNT_BITS-1:0] start_count;
   logic                              fwd_prev, bwd_prev, fwd_mode, bwd_mode, finished;
   logic signed [DRIVE_BITS-1:0]      drive;

   int mismatches = 0;
   int ticks_accepted = 0;
   int outputs_checked = 0;
   int targets_reached = 0;
   int input_stalls = 0;
   int queued_ticks = 0;
   longint plan_target;

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("mismatch on output %0d: %s got %0h, want %0h", outputs_checked, what, got, want);
      mismatches++;
   endtask

   function automatic drive_status_type advance_sequencer(input tick_type t);
      drive_status_type r;
      logic all_hit;
      logic signed [COUNT_BITS-1:0] d;
      logic [COUNT_BITS-1:0] raw;
      logic [COUNT_BITS:0] mag;
      longint tgt;
      r = '0;
      if (t.stop_key) begin
         fwd_mode = 1'b0;
         bwd_mode = 1'b0;
         finished = 1'b0;
         drive = '0;
      end
      if (t.forward_key && !fwd_prev) begin
         fwd_mode = 1'b1;
         bwd_mode = 1'b0;
         finished = 1'b0;
         start_count = t.count;
         drive = signed'({1'b0, magnitude_cfg});
      end
      if (t.backward_key && !bwd_prev) begin
         bwd_mode = 1'b1;
         fwd_mode = 1'b0;
         finished = 1'b0;
         start_count = t.count;
         drive = -signed'({1'b0, magnitude_cfg});
      end
      fwd_prev = t.forward_key;
      bwd_prev = t.backward_key;
      if ((fwd_mode || bwd_mode) && drive != 0 && !finished) begin
         all_hit = 1'b1;
         tgt = longint'(target_cfg);
         for (int i = 0; i < WHEELS; i++) begin
            d = t.count[i] - start_count[i];
            if (drive > 0 ? (longint'(d) < tgt) : (longint'(d) > -tgt))
               all_hit = 1'b0;
         end
         if (all_hit) begin
            raw = t.count[0] - start_count[0];
            mag = raw[COUNT_BITS-1] ? ({1'b0, ~raw} + 1'b1) : {1'b0, raw};
            finished = 1'b1;
            drive = '0;
            r.reached = 1'b1;
            r.travelled = (mag > TRAVEL_MAX) ? TRAVEL_MAX : mag[TARGET_BITS-1:0];
         end
      end
      r.motor_drive = drive;
      r.going_forward = fwd_mode;
      r.going_backward = bwd_mode;
      return r;
   endfunction

   // input side: bursts with gaps
   int burst_left = 0;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (ticks_to_send.size() > 0) begin
            req_tdata <= REQ_W'(ticks_to_send.pop_front());
            req_tvalid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 40);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         start_count = '0;
         fwd_prev = 1'b0;
         bwd_prev = 1'b0;
         fwd_mode = 1'b0;
         bwd_mode = 1'b0;
         finished = 1'b0;
         drive = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_outputs.push_back(
               advance_sequencer(tick_type'(req_tdata[$bits(tick_type)-1:0])));
            ticks_accepted++;
         end
         if (req_tvalid && !req_tready)
            input_stalls++;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         target_cfg = TARGET_RESET;
         magnitude_cfg = MAGNITUDE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TARGET_COUNT: begin
               target_cfg = csr_data[TARGET_BITS-1:0];
            end
            CSR_DRIVE_MAGNITUDE: begin
               magnitude_cfg = csr_data[MAGNITUDE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // output side: stall pattern of its own plus long hold-offs
   rx_pattern_type rx_mode = RX_OPEN;
   int rx_cycle = 0;
   int hold_left = 0;
   int next_hold = 500;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 64 == 0)
            rx_mode = rx_pattern_type'($urandom_range(0, 3));
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_cycle >= next_hold && req_tvalid) begin
            hold_left = 200;
            next_hold = rx_cycle + 3000;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_OPEN:     rsp_tready <= 1'b1;
               RX_LIGHT:    rsp_tready <= ($urandom_range(0, 3) != 0);
               RX_HEAVY:    rsp_tready <= ($urandom_range(0, 3) == 0);
               default:     rsp_tready <= ((rx_cycle % 5) != 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      drive_status_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(drive_status_type)-1:0];
         if (predicted_outputs.size() == 0) begin
            flag_mismatch("unexpected transfer", 64'(got), 64'(0));
         end else begin
            want = predicted_outputs.pop_front();
            if (got.motor_drive !== want.motor_drive)
               flag_mismatch("motor_drive", 64'(got.motor_drive), 64'(want.motor_drive));
            if (got.going_forward !== want.going_forward)
               flag_mismatch("going_forward", 64'(got.going_forward), 64'(want.going_forward));
            if (got.going_backward !== want.going_backward)
               flag_mismatch("going_backward", 64'(got.going_backward),
                             64'(want.going_backward));
            if (got.reached !== want.reached)
               flag_mismatch("reached", 64'(got.reached), 64'(want.reached));
            if (got.travelled !== want.travelled)
               flag_mismatch("travelled", 64'(got.travelled), 64'(want.travelled));
            if (want.reached)
               targets_reached++;
         end
         outputs_checked++;
      end
   end

   function automatic tick_type tick_of(input logic [COUNT_BITS-1:0] c, input logic stop,
                                        input logic fwd, input logic bwd);
      tick_type t;
      for (int i = 0; i < WHEELS; i++)
         t.count[i] = c;
      t.stop_key = stop;
      t.forward_key = fwd;
      t.backward_key = bwd;
      return t;
   endfunction

   task automatic queue_tick(input tick_type t);
      ticks_to_send.push_back(t);
      queued_ticks++;
   endtask

   task automatic settle();
      while (ticks_to_send.size() > 0 || req_tvalid || predicted_outputs.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic add_noise(input int n);
      tick_type t;
      repeat (n) begin
         for (int i = 0; i < WHEELS; i++)
            t.count[i] = $urandom;
         t.stop_key = ($urandom_range(0, 3) == 0);
         t.forward_key = $urandom_range(0, 1);
         t.backward_key = $urandom_range(0, 1);
         queue_tick(t);
      end
   endtask

   // release, key edge, then wheels creeping toward the target with jitter
   task automatic add_move();
      tick_type t;
      logic [WHEELS-1:0][COUNT_BITS-1:0] base;
      longint prog[WHEELS];
      longint step;
      logic backward;
      logic done;
      int extra, n;
      backward = $urandom_range(0, 1);
      step = plan_target / 3 + 1;
      extra = $urandom_range(0, 2);
      for (int i = 0; i < WHEELS; i++) begin
         base[i] = $urandom;
         prog[i] = 0;
      end
      t = tick_of($urandom, ($urandom_range(0, 7) == 0), 1'b0, 1'b0);
      t.count[1] = $urandom;
      queue_tick(t);
      t.count = base;
      t.stop_key = ($urandom_range(0, 9) == 0);
      t.forward_key = !backward || ($urandom_range(0, 5) == 0);
      t.backward_key = backward || ($urandom_range(0, 5) == 0);
      queue_tick(t);
      n = 0;
      while (n < 30 && extra >= 0) begin
         done = 1'b1;
         for (int i = 0; i < WHEELS; i++) begin
            prog[i] += $urandom_range(0, int'(step));
            if ($urandom_range(0, 7) == 0)
               prog[i] -= $urandom_range(0, int'(step / 4));
            t.count[i] = COUNT_BITS'(longint'(base[i]) + (backward ? -prog[i] : prog[i]));
            if (prog[i] < plan_target)
               done = 1'b0;
         end
         t.forward_key = backward ? ($urandom_range(0, 19) == 0) : ($urandom_range(0, 3) != 0);
         t.backward_key = backward ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0);
         t.stop_key = ($urandom_range(0, 39) == 0);
         queue_tick(t);
         if (done)
            extra--;
         n++;
      end
   endtask

   task automatic run_phase(input longint tgt, input int mag, input int budget);
      int stop_at;
      settle();
      write_reg(CSR_TARGET_COUNT, {1'($urandom_range(0, 1)), TARGET_BITS'(tgt)});
      write_reg(CSR_DRIVE_MAGNITUDE, {17'($urandom), MAGNITUDE_BITS'(mag)});
      plan_target = tgt;
      stop_at = queued_ticks + budget;
      while (queued_ticks < stop_at) begin
         if ($urandom_range(0, 5) == 0)
            add_noise($urandom_range(1, 5));
         else
            add_move();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // defaults after reset: forward move of exactly the default target
      queue_tick(tick_of(32'd0, 1'b0, 1'b0, 1'b0));
      queue_tick(tick_of(32'd0, 1'b0, 1'b1, 1'b0));
      queue_tick(tick_of(32'd2499, 1'b0, 1'b1, 1'b0));
      queue_tick(tick_of(32'd2500, 1'b0, 1'b1, 1'b0));
      settle();

      // widest target and drive: full-scale travel and saturation
      write_reg(CSR_TARGET_COUNT, 32'h7FFF_FFFF);
      write_reg(CSR_DRIVE_MAGNITUDE, 32'h0000_7FFF);
      queue_tick(tick_of(32'd0, 1'b0, 1'b0, 1'b0));
      queue_tick(tick_of(32'd0, 1'b0, 1'b1, 1'b0));
      queue_tick(tick_of(32'h7FFF_FFFF, 1'b0, 1'b1, 1'b0));
      queue_tick(tick_of(32'h8000_0000, 1'b0, 1'b0, 1'b0));
      queue_tick(tick_of(32'd0, 1'b0, 1'b0, 1'b1));
      queue_tick(tick_of(32'h8000_0000, 1'b0, 1'b0, 1'b1));
      queue_tick(tick_of($urandom, 1'b1, 1'b0, 1'b0));
      queue_tick(tick_of($urandom, 1'b0, 1'b1, 1'b1));
      queue_tick(tick_of($urandom, 1'b0, 1'b0, 1'b0));
      queue_tick(tick_of($urandom, 1'b1, 1'b1, 1'b0));
      queue_tick(tick_of($urandom, 1'b1, 1'b1, 1'b0));
      settle();

      // ignored index, then zero target with the smallest drive
      write_reg(CSR_INDEX_UNUSED, 32'hFFFF_FFFF);
      write_reg(CSR_TARGET_COUNT, 32'h8000_0000);
      write_reg(CSR_DRIVE_MAGNITUDE, 32'hFFFF_0001);
      queue_tick(tick_of($urandom, 1'b0, 1'b0, 1'b0));
      queue_tick(tick_of($urandom, 1'b0, 1'b1, 1'b0));
      queue_tick(tick_of($urandom, 1'b0, 1'b0, 1'b0));
      queue_tick(tick_of($urandom, 1'b0, 1'b0, 1'b1));
      settle();

      // zero drive: mode set, move never finishes
      write_reg(CSR_DRIVE_MAGNITUDE, 32'h0000_0000);
      queue_tick(tick_of($urandom, 1'b0, 1'b0, 1'b0));
      queue_tick(tick_of($urandom, 1'b0, 1'b1, 1'b0));
      queue_tick(tick_of($urandom, 1'b0, 1'b1, 1'b0));

      run_phase($urandom_range(1, 300), $urandom_range(1, 32767), 260);
      run_phase(0, 1, 150);
      run_phase(longint'($urandom_range(32'h4000_0000, 32'h7FFF_FFFF)), 32767, 200);
      run_phase($urandom_range(1, 5000), 0, 80);
      run_phase($urandom_range(1, 40), $urandom_range(1, 32767), 260);
      run_phase(longint'($urandom_range(0, 32'h7FFF_FFFF)), $urandom_range(1, 32767), 200);
      run_phase(1, 16384, 150);

      settle();
      $display("%0d ticks driven over eleven register settings, %0d outputs checked",
               ticks_accepted, outputs_checked);
      $display("%0d targets reached, %0d cycles of input backpressure",
               targets_reached, input_stalls);
      if (mismatches == 0 && predicted_outputs.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("timeout with %0d outputs outstanding", predicted_outputs.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/fdds_pkg.sv
hw/rtl/fdds_wheel_check.sv
hw/rtl/fixed_distance_drive_sequencer.sv
dv/fixed_distance_drive_sequencer_test.sv
